@@ rtl/core/lbwc_pkg.sv @@
package lbwc_pkg;

  localparam int PIXEL_W     = 8;
  localparam int CNT_W       = 11;
  localparam int COEF_W      = 40;
  localparam int COEF_ROWS   = 5;
  localparam int KCOEF_W     = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int FILT_W      = 29;
  localparam int PROD_W      = 16;
  localparam int SUM_W       = 22;
  localparam int MAG_W       = 20;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0] RECIP_255 = 21'd1052689;
  localparam logic [MAG_W-1:0]   ROUND_BIAS = 20'd127;

  localparam int DEF_WINDOW_SIZE = 3;
  localparam int DEF_MAX_COLS    = 1024;

  localparam logic [CNT_W-1:0] RESET_ROWS = 11'd480;
  localparam logic [CNT_W-1:0] RESET_COLS = 11'd640;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW4  = 3'd6;

  typedef struct packed {
    logic nonzero;
    logic frame_end;
  } meta_t;

endpackage

@@ rtl/core/lbwc_if.sv @@
interface lbwc_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [lbwc_pkg::PIXEL_W-1:0] pixel;

  modport source(output valid, output pixel, input ready);
  modport sink(input valid, input pixel, output ready);
endinterface

interface lbwc_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [lbwc_pkg::FILT_W-1:0] filtered;
  logic                               frame_end;

  modport source(output valid, output filtered, output frame_end, input ready);
  modport sink(input valid, input filtered, input frame_end, output ready);
endinterface

@@ rtl/core/lbwc_line_mem.sv @@
module lbwc_line_mem #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] wr_q;
  logic             fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
      wr_q <= wr_data;
      fwd  <= wr_en && (wr_addr == rd_addr);
    end
  end

  // forward a write that lands on the entry being read
  assign rd_data = fwd ? wr_q : rd_q;

endmodule

@@ rtl/core/lbwc_window.sv @@
module lbwc_window #(
  parameter int W = 3
) (
  input  logic                                 clk,
  input  logic                                 shift,
  input  logic [lbwc_pkg::PIXEL_W-1:0]         pixel,
  input  logic [lbwc_pkg::PIXEL_W*(W-1)-1:0]   line_q,
  input  logic [lbwc_pkg::COEF_W-1:0]          coef [lbwc_pkg::COEF_ROWS],
  output logic [lbwc_pkg::PIXEL_W*(W-1)-1:0]   line_wr,
  output logic signed [lbwc_pkg::PROD_W-1:0]   prod [W*W]
);

  localparam int PW = lbwc_pkg::PIXEL_W;
  localparam int KW = lbwc_pkg::KCOEF_W;

  logic [PW-1:0] win      [W][W];
  logic [PW-1:0] win_next [W][W];
  logic [PW-1:0] column   [W];

  always_comb begin
    for (int i = 0; i < W - 1; i++) begin
      column[i] = line_q[PW*i +: PW];
    end
    column[W-1] = pixel;
    for (int k = 0; k < W - 1; k++) begin
      line_wr[PW*k +: PW] = column[k+1];
    end
  end

  always_comb begin
    for (int i = 0; i < W; i++) begin
      for (int j = 0; j < W; j++) begin
        if (!shift) begin
          win_next[i][j] = win[i][j];
        end else if (j == W - 1) begin
          win_next[i][j] = column[i];
        end else begin
          win_next[i][j] = win[i][j+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    win <= win_next;
  end

  always_comb begin
    for (int i = 0; i < W; i++) begin
      for (int j = 0; j < W; j++) begin
        prod[i*W+j] = $signed(coef[i][KW*j +: KW]) * $signed({1'b0, win_next[i][j]});
      end
    end
  end

endmodule

@@ rtl/core/lbwc_sum_scale.sv @@
module lbwc_sum_scale #(
  parameter int W = 3
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [lbwc_pkg::PROD_W-1:0] prod [W*W],
  input  lbwc_pkg::meta_t                    meta,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [lbwc_pkg::FILT_W-1:0] filtered,
  output logic                               frame_end
);

  localparam int SW = lbwc_pkg::SUM_W;
  localparam int MW = lbwc_pkg::MAG_W;
  localparam int XW = lbwc_pkg::MAG_W + lbwc_pkg::RECIP_W;
  localparam int QW = lbwc_pkg::FILT_W - 1;

  logic v_a, v_b, v_c, v_d;
  logic adv_a, adv_b, adv_c, adv_d, adv_e;

  logic signed [lbwc_pkg::PROD_W-1:0] prod_a [W*W];
  logic                               fe_a;
  logic signed [SW-1:0]               row_b [W];
  logic                               fe_b;
  logic                               neg_c;
  logic [MW-1:0]                      mag_c;
  logic                               fe_c;
  logic                               neg_d;
  logic [MW-1:0]                      mag_d;
  logic [XW-1:0]                      scaled_d;
  logic                               fe_d;

  logic signed [SW-1:0] row_sum [W];
  logic signed [SW-1:0] total;
  logic signed [SW-1:0] total_abs;
  logic [MW-1:0]        biased;
  logic [QW-1:0]        quot;

  assign adv_e    = !out_valid || out_ready;
  assign adv_d    = !v_d || adv_e;
  assign adv_c    = !v_c || adv_d;
  assign adv_b    = !v_b || adv_c;
  assign adv_a    = !v_a || adv_b;
  assign in_ready = adv_a;

  always_comb begin
    for (int i = 0; i < W; i++) begin
      row_sum[i] = '0;
      for (int j = 0; j < W; j++) begin
        row_sum[i] = row_sum[i] + SW'(prod_a[i*W+j]);
      end
    end
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < W; i++) begin
      total = total + row_b[i];
    end
    total_abs = total[SW-1] ? -total : total;
  end

  assign biased = mag_c + lbwc_pkg::ROUND_BIAS;
  // x * 65536 / 255 = 257 x + (x + bias) / 255 with the bias folded in
  assign quot = QW'({mag_d, 8'b0}) + QW'(mag_d) + QW'(scaled_d >> lbwc_pkg::RECIP_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      v_b       <= 1'b0;
      v_c       <= 1'b0;
      v_d       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) v_a <= in_valid;
      if (adv_b) v_b <= v_a;
      if (adv_c) v_c <= v_b;
      if (adv_d) v_d <= v_c;
      if (adv_e) out_valid <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      for (int k = 0; k < W * W; k++) begin
        prod_a[k] <= meta.nonzero ? prod[k] : '0;
      end
      fe_a <= meta.frame_end;
    end
    if (adv_b) begin
      row_b <= row_sum;
      fe_b  <= fe_a;
    end
    if (adv_c) begin
      neg_c <= total[SW-1];
      mag_c <= total_abs[MW-1:0];
      fe_c  <= fe_b;
    end
    if (adv_d) begin
      neg_d    <= neg_c;
      mag_d    <= mag_c;
      scaled_d <= XW'(biased) * XW'(lbwc_pkg::RECIP_255);
      fe_d     <= fe_c;
    end
    if (adv_e) begin
      filtered  <= neg_d ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      frame_end <= fe_d;
    end
  end

endmodule

@@ rtl/core/line_buffer_window_convolution.sv @@
// channel   side  handshake        payload
// pix_in    in    valid / ready    pixel[7:0]
// res_out   out   valid / ready    filtered[28:0] signed Q16, frame_end
// cfg       in    cfg_write        cfg_index[2:0], cfg_data[39:0]
//
// One pixel tick transfers per cycle, sustained, with the output taken.
// The line memory sets that rate: one read at transfer, one write back as the tick moves on.
// A result passes the input stage and sum pipeline; other ticks drop at the input stage.
// Synchronous reset clears ticks, valids and registers; line memory and window start undefined.
// A stalled output backs up through the pipeline; input transfers go on until it fills.
module line_buffer_window_convolution #(
  parameter int WINDOW_SIZE = lbwc_pkg::DEF_WINDOW_SIZE,
  parameter int MAX_COLS    = lbwc_pkg::DEF_MAX_COLS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [lbwc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbwc_pkg::COEF_W-1:0]      cfg_data,
  lbwc_pixel_if.sink                       pix_in,
  lbwc_result_if.source                    res_out
);

  localparam int ADDR_W = $clog2(MAX_COLS);
  localparam int LINE_W = lbwc_pkg::PIXEL_W * (WINDOW_SIZE - 1);
  localparam int CW     = lbwc_pkg::CNT_W;
  localparam int CMP_W  = lbwc_pkg::CNT_W + 2;

  logic [CW-1:0]                 frame_rows;
  logic [CW-1:0]                 frame_cols;
  logic [lbwc_pkg::COEF_W-1:0]   coef [lbwc_pkg::COEF_ROWS];
  logic [CW-1:0]                 tick_row;
  logic [CW-1:0]                 tick_col;

  logic                          s1_v;
  logic                          s1_in_image;
  logic                          s1_emit;
  lbwc_pkg::meta_t               s1_meta;
  logic [lbwc_pkg::PIXEL_W-1:0]  s1_pixel;
  logic [ADDR_W-1:0]             s1_addr;

  logic [CMP_W-1:0]              cols_eff;
  logic [CMP_W-1:0]              col_ext;
  logic                          in_image;
  logic                          row_pad;
  logic                          col_pad;
  logic                          accept;
  logic                          s1_fire;
  logic                          sum_ready;
  logic [LINE_W-1:0]             line_q;
  logic [LINE_W-1:0]             line_wr;
  logic signed [lbwc_pkg::PROD_W-1:0] prod [WINDOW_SIZE*WINDOW_SIZE];
  lbwc_pkg::meta_t               meta_next;
  logic [lbwc_pkg::CFG_IDX_W-1:0] coef_sel;

  assign cols_eff = ({2'b0, frame_cols} > CMP_W'(MAX_COLS)) ? CMP_W'(MAX_COLS)
                                                             : {2'b0, frame_cols};
  assign col_ext  = {2'b0, tick_col};
  assign row_pad  = tick_row >= frame_rows;
  assign col_pad  = col_ext >= cols_eff;
  assign in_image = !row_pad && !col_pad;

  assign meta_next.nonzero   = in_image && (tick_row >= CW'(WINDOW_SIZE - 1))
                               && (tick_col >= CW'(WINDOW_SIZE - 1));
  assign meta_next.frame_end = row_pad && col_pad;

  assign s1_fire      = s1_v && (!s1_emit || sum_ready);
  assign pix_in.ready = !s1_v || s1_fire;
  assign accept       = pix_in.valid && pix_in.ready;
  assign coef_sel     = cfg_index - lbwc_pkg::REG_COEF_ROW0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= lbwc_pkg::RESET_ROWS;
      frame_cols <= lbwc_pkg::RESET_COLS;
      for (int k = 0; k < lbwc_pkg::COEF_ROWS; k++) begin
        coef[k] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index) inside
        lbwc_pkg::REG_FRAME_ROWS: frame_rows <= cfg_data[CW-1:0];
        lbwc_pkg::REG_FRAME_COLS: frame_cols <= cfg_data[CW-1:0];
        [lbwc_pkg::REG_COEF_ROW0:lbwc_pkg::REG_COEF_ROW4]: coef[coef_sel] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_row <= '0;
      tick_col <= '0;
      s1_v     <= 1'b0;
    end else begin
      if (accept) begin
        if (col_pad) begin
          tick_col <= '0;
          tick_row <= row_pad ? '0 : tick_row + 1'b1;
        end else begin
          tick_col <= tick_col + 1'b1;
        end
      end
      if (accept) begin
        s1_v <= 1'b1;
      end else if (s1_fire) begin
        s1_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_in_image <= in_image;
      s1_emit     <= (tick_row != '0) && (tick_col != '0);
      s1_meta     <= meta_next;
      s1_pixel    <= pix_in.pixel;
      s1_addr     <= col_ext[ADDR_W-1:0];
    end
  end

  lbwc_line_mem #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_COLS)
  ) u_line_mem (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(col_ext[ADDR_W-1:0]),
    .wr_en  (s1_fire && s1_in_image),
    .wr_addr(s1_addr),
    .wr_data(line_wr),
    .rd_data(line_q)
  );

  lbwc_window #(
    .W(WINDOW_SIZE)
  ) u_window (
    .clk    (clk),
    .shift  (s1_fire && s1_in_image),
    .pixel  (s1_pixel),
    .line_q (line_q),
    .coef   (coef),
    .line_wr(line_wr),
    .prod   (prod)
  );

  lbwc_sum_scale #(
    .W(WINDOW_SIZE)
  ) u_sum_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_v && s1_emit),
    .in_ready (sum_ready),
    .prod     (prod),
    .meta     (s1_meta),
    .out_valid(res_out.valid),
    .out_ready(res_out.ready),
    .filtered (res_out.filtered),
    .frame_end(res_out.frame_end)
  );

endmodule

@@ rtl/core/lbwc_checker.sv @@
module lbwc_props (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [lbwc_pkg::FILT_W-1:0] filtered,
  input logic                               frame_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(filtered) && $stable(frame_end))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown straight after reset");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> filtered == '0)
    else $error("frame end result lies outside the image but is not zero");

endmodule

bind line_buffer_window_convolution lbwc_props u_lbwc_props (
  .clk      (clk),
  .rst      (rst),
  .out_valid(res_out.valid),
  .out_ready(res_out.ready),
  .filtered (res_out.filtered),
  .frame_end(res_out.frame_end)
);

@@ verif/lbwc_checker.sv @@
`timescale 1ns / 100ps

module lbwc_checker import lbwc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  lbwc_pixel_if                pix,
  lbwc_result_if               res,
  output int                   fail_count,
  output int                   outstanding,
  output int                   checked
);

  localparam int WIN      = DEF_WINDOW_SIZE;
  localparam int MAXC     = DEF_MAX_COLS;

  typedef struct packed {
    logic [FILT_W-1:0] filtered;
    logic              frame_end;
  } conv_result_t;

  logic [CNT_W-1:0]   rows_q;
  logic [CNT_W-1:0]   cols_q;
  logic [COEF_W-1:0]  coef_q [COEF_ROWS];
  logic [PIXEL_W-1:0] lines [WIN][MAXC];
  logic [PIXEL_W-1:0] win [WIN][WIN];
  int                 row_pos;
  int                 col_pos;
  int                 fails;
  int                 n_checked;
  conv_result_t       filtered_q [$];
  conv_result_t       head;

  function automatic void note_fail(input string msg);
    fails++;
    $display("%0t %s", $time, msg);
  endfunction

  task automatic conv_tick(input logic [PIXEL_W-1:0] px);
    int           eff_cols;
    bit           in_image;
    longint       acc;
    longint       mag;
    longint       q;
    conv_result_t r;
    eff_cols = (int'(cols_q) > MAXC) ? MAXC : int'(cols_q);
    in_image = (row_pos < int'(rows_q)) && (col_pos < eff_cols);
    if (in_image) begin
      for (int i = 0; i < WIN - 1; i++) lines[i][col_pos] = lines[i+1][col_pos];
      lines[WIN-1][col_pos] = px;
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN - 1; j++) win[i][j] = win[i][j+1];
        win[i][WIN-1] = lines[i][col_pos];
      end
    end
    if (row_pos > 0 && col_pos > 0) begin
      acc = 0;
      if (in_image && row_pos >= WIN - 1 && col_pos >= WIN - 1) begin
        for (int i = 0; i < WIN; i++) begin
          for (int j = 0; j < WIN; j++) begin
            acc += longint'($signed(coef_q[i][KCOEF_W*j +: KCOEF_W])) * longint'(win[i][j]);
          end
        end
      end
      mag = (acc < 0) ? -acc : acc;
      q = (mag * 65536 + 127) / 255;
      if (acc < 0) q = -q;
      r.filtered  = q[FILT_W-1:0];
      r.frame_end = (row_pos >= int'(rows_q)) && (col_pos >= eff_cols);
      filtered_q.push_back(r);
    end
    if (col_pos >= eff_cols) begin
      col_pos = 0;
      row_pos = (row_pos >= int'(rows_q)) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  initial begin
    fails      = 0;
    n_checked  = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      rows_q  = RESET_ROWS;
      cols_q  = RESET_COLS;
      row_pos = 0;
      col_pos = 0;
      for (int i = 0; i < COEF_ROWS; i++) coef_q[i] = '0;
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < MAXC; j++) lines[i][j] = '0;
        for (int j = 0; j < WIN; j++) win[i][j] = '0;
      end
      filtered_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_ROWS: rows_q = cfg_data[CNT_W-1:0];
          REG_FRAME_COLS: cols_q = cfg_data[CNT_W-1:0];
          default: begin
            if (cfg_index >= REG_COEF_ROW0 && cfg_index <= REG_COEF_ROW4)
              coef_q[cfg_index - REG_COEF_ROW0] = cfg_data;
          end
        endcase
      end
      if (res.valid && res.ready) begin
        if (filtered_q.size() == 0) begin
          note_fail($sformatf("unexpected result: expected none, actual filtered %0d frame_end %0b",
                              res.filtered, res.frame_end));
        end else begin
          head = filtered_q.pop_front();
          n_checked++;
          if (res.filtered !== head.filtered)
            note_fail($sformatf("filtered mismatch: expected %0d, actual %0d",
                                $signed(head.filtered), res.filtered));
          if (res.frame_end !== head.frame_end)
            note_fail($sformatf("frame_end mismatch: expected %0b, actual %0b",
                                head.frame_end, res.frame_end));
        end
      end
      if (pix.valid && pix.ready) conv_tick(pix.pixel);
    end
    fail_count  <= fails;
    outstanding <= filtered_q.size();
    checked     <= n_checked;
  end

endmodule

@@ verif/tb_line_buffer_window_convolution.sv @@
`timescale 1ns / 100ps

module tb_line_buffer_window_convolution;
  import lbwc_pkg::*;

  localparam int     SETTLE       = 16;
  localparam int     RANDOM_TICKS = 1150;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     IDLE_PCT     = 8;
  localparam int     CALM_FROM    = 600;
  localparam int     CALM_TO      = 1200;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [COEF_W-1:0]    KERN_MIN   = {5{8'h80}};
  localparam logic [COEF_W-1:0]    KERN_MAX   = {5{8'h7f}};

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  lbwc_pixel_if  pix ();
  lbwc_result_if res ();

  int               fails;
  int               outstanding;
  int               checked;
  int               cycles = 0;
  int               sent = 0;
  int               frames = 0;
  int               rows_set;
  int               cols_set;
  int               trow = 0;
  int               tcol = 0;
  logic [COEF_W-1:0] kern [COEF_ROWS];

  line_buffer_window_convolution dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix.sink),
    .res_out   (res.source)
  );

  lbwc_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pix         (pix),
    .res         (res),
    .fail_count  (fails),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit calm();
    return cycles >= CALM_FROM && cycles < CALM_TO;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    res.ready <= calm() ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int eff_cols(input int c);
    return (c > DEF_MAX_COLS) ? DEF_MAX_COLS : c;
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_pixel(input int fixed);
    int roll;
    roll = $urandom_range(99);
    if (fixed >= 0) return PIXEL_W'(fixed);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return PIXEL_W'($urandom);
  endfunction

  task automatic send_tick(input logic [PIXEL_W-1:0] px);
    while (!calm() && $urandom_range(99) < IDLE_PCT) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel <= px;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    sent++;
    if (tcol >= eff_cols(cols_set)) begin
      tcol = 0;
      trow = (trow >= rows_set) ? 0 : trow + 1;
    end else begin
      tcol++;
    end
  endtask

  task automatic settle();
    pix.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs();
    logic [COEF_W-1:0] vals [8];
    vals[REG_FRAME_ROWS] = {29'($urandom), CNT_W'(rows_set)};
    vals[REG_FRAME_COLS] = {29'($urandom), CNT_W'(cols_set)};
    for (int k = 0; k < COEF_ROWS; k++) vals[REG_COEF_ROW0 + k] = kern[k];
    vals[REG_UNUSED] = {8'($urandom), 32'($urandom)};
    for (int k = 0; k < 8; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_data  <= vals[k];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic run_frame(input int r, input int c, input int cut_after, input int fixed);
    int k;
    settle();
    rows_set = r;
    cols_set = c;
    program_regs();
    k = 0;
    do begin
      if (k == cut_after) begin
        settle();
        cols_set = $urandom_range(tcol);
        if ($urandom_range(1)) rows_set = $urandom_range(trow);
        program_regs();
      end
      send_tick(pick_pixel(fixed));
      k++;
    end while (trow != 0 || tcol != 0);
    frames++;
  endtask

  task automatic pick_kernel();
    int roll;
    roll = $urandom_range(99);
    for (int k = 0; k < COEF_ROWS; k++) begin
      if (roll < 15) kern[k] = KERN_MIN;
      else if (roll < 30) kern[k] = KERN_MAX;
      else kern[k] = {8'($urandom), 32'($urandom)};
    end
  endtask

  initial begin
    int base;
    int r;
    int c;
    int total;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    pix.valid = 1'b0;
    pix.pixel = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < COEF_ROWS; k++) kern[k] = KERN_MIN;
    run_frame(3, 3, -1, 255);
    for (int k = 0; k < COEF_ROWS; k++) kern[k] = KERN_MAX;
    run_frame(3, 3, 11, 255);

    base = sent;
    while (sent - base < RANDOM_TICKS) begin
      pick_kernel();
      r = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 9);
      c = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 12);
      total = (r + 1) * (c + 1);
      if (total > 2 && $urandom_range(4) == 0) run_frame(r, c, $urandom_range(1, total - 1), -1);
      else run_frame(r, c, -1, -1);
    end

    settle();
    $display("covered %0d frames over %0d pixel ticks, %0d results checked", frames, sent, checked);
    $display("sizes from empty frames up to 9 rows by 12 columns, extreme kernels, mid-frame shrinks");
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
